FILE: sv/marked_varint_codec_unit_assert.svh
// Assertion helpers for the codec unit
`ifndef MARKED_VARINT_CODEC_UNIT_ASSERT_SVH
`define MARKED_VARINT_CODEC_UNIT_ASSERT_SVH

// Same-cycle implication under reset
`define MVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define MVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mvc_pkg.sv
`timescale 1ns / 1ps

package mvc_pkg;

    localparam int MAX_BYTES  = 4;
    localparam int LANES      = 4;
    localparam int GROUP_BITS = 7;
    localparam int MARK_SPAN  = 6;

    localparam logic [2:0] ROOM_LIMIT = 3'd5;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam logic LEVEL_REG_IDX = 1'b0;

    typedef struct packed {
        logic [4:0]             pad;
        logic [2:0]             room;
        logic [LANES-1:0][7:0]  in_bytes;
        logic [31:0]            index_value;
    } in_item_t;

    typedef struct packed {
        logic                   pad;
        logic [2:0]             byte_count;
        logic [LANES-1:0][7:0]  out_bytes;
        logic [27:0]            out_value;
    } result_t;

    typedef struct packed {
        logic       update;
        logic [2:0] level;
    } level_upd_t;

    typedef struct packed {
        logic [LANES-1:0][7:0]  out_bytes;
        logic [2:0]             byte_count;
    } enc_result_t;

    typedef struct packed {
        logic [27:0]    out_value;
        logic [2:0]     byte_count;
        level_upd_t     level_upd;
    } dec_result_t;

    function automatic logic [2:0] clamp_room(input logic [2:0] room);
        return (room > ROOM_LIMIT) ? ROOM_LIMIT : room;
    endfunction

endpackage

FILE: sv/marked_varint_codec_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                          Carries
// s_        in   s_tvalid s_tready s_tdata s_tuser  one request: action, marker flag, value,
//                                                   four bytes, room
// m_        out  m_tvalid m_tready m_tdata          one result: value, four bytes, count
// apb       in   psel penable pwrite paddr pwdata   level_setting at byte address 0
//                prdata pready
//
// One request per cycle sustained while m_tready stays high; input register, then result register.
// Encode and decode run as short logic between the two registers; the level register
// updates on the same edge that loads the result, so the next request sees it.
// Reset clears the valid flags, current level and level_setting; nothing else is cleared.
// When m_tready is low the result holds, the input register fills and s_tready drops.

`include "marked_varint_codec_unit_assert.svh"

module marked_varint_codec_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // index_value[31:0], in_byte0..3 [63:32], room[66:64], zero
    input  logic [1:0]  s_tuser,   // action[0], marked[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_value[27:0], out_byte0..3 [59:28], byte_count[62:60]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                   in_valid_reg;
    mvc_pkg::in_item_t      in_item_reg;
    logic                   in_action_reg;
    logic                   in_marked_reg;
    logic                   m_valid_reg;
    mvc_pkg::result_t       result_reg;
    mvc_pkg::result_t       result_next;
    logic                   advance;
    logic                   s_take;
    logic [2:0]             level;
    mvc_pkg::enc_result_t   enc_res;
    mvc_pkg::dec_result_t   dec_res;
    mvc_pkg::level_upd_t    level_upd;
    logic                   cfg_wr_level;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg   <= mvc_pkg::in_item_t'(s_tdata);
            in_action_reg <= s_tuser[0];
            in_marked_reg <= s_tuser[1];
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    mvc_encoder u_encoder
    (
        .level       (level),
        .marked      (in_marked_reg),
        .index_value (in_item_reg.index_value),
        .room        (in_item_reg.room),
        .result      (enc_res)
    );

    mvc_decoder u_decoder
    (
        .marked   (in_marked_reg),
        .in_bytes (in_item_reg.in_bytes),
        .room     (in_item_reg.room),
        .result   (dec_res)
    );

    always_comb
    begin
        result_next     = '0;
        level_upd       = '0;
        level_upd.level = dec_res.level_upd.level;
        unique case (in_action_reg)
            mvc_pkg::ACT_ENCODE:
            begin
                result_next.out_bytes  = enc_res.out_bytes;
                result_next.byte_count = enc_res.byte_count;
            end
            mvc_pkg::ACT_DECODE:
            begin
                result_next.out_value  = dec_res.out_value;
                result_next.byte_count = dec_res.byte_count;
                // commit the new level only as the request moves on
                level_upd.update = dec_res.level_upd.update && in_valid_reg && advance;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    mvc_level_regs u_level_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .level_upd (level_upd),
        .level     (level)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    assign cfg_wr_level = psel && penable && pwrite && pready
                          && (paddr[2] == mvc_pkg::LEVEL_REG_IDX);

    `MVC_ASSERT_NEXT(a_cfg_loads_level, clk, rst_n, cfg_wr_level, level == $past(pwdata[2:0]), "level not loaded by write")
    `MVC_ASSERT_IMPLY(a_zero_count_empty, clk, rst_n, m_valid_reg && result_reg.byte_count == 3'd0, result_reg.out_value == 28'd0 && result_reg.out_bytes == '0, "zero count with payload")
    `MVC_ASSERT_IMPLY(a_overflow_continues, clk, rst_n, m_valid_reg && result_reg.byte_count == 3'(mvc_pkg::MAX_BYTES + 1), result_reg.out_bytes[mvc_pkg::MAX_BYTES-1][7], "overflow without continuation")
    `MVC_ASSERT_NEXT(a_stall_keeps_input, clk, rst_n, in_valid_reg && !advance, in_valid_reg, "input request lost in stall")

endmodule

FILE: sv/mvc_encoder.sv
`timescale 1ns / 1ps

module mvc_encoder
(
    input  logic [2:0]          level,
    input  logic                marked,
    input  logic [31:0]         index_value,
    input  logic [2:0]          room,
    output mvc_pkg::enc_result_t result
);

    logic [31:0]                    val;
    logic [mvc_pkg::LANES-1:0]      cont;
    logic [2:0]                     need;
    logic [2:0]                     room_c;
    logic [2:0]                     count;
    logic                           done;

    always_comb
    begin
        val = index_value;
        if (marked && level != 3'd0)
        begin
            val = (index_value << level) | (32'd1 << (level - 3'd1));
        end

        // continuation: something remains above this group
        for (int k = 0; k < mvc_pkg::LANES; k++)
        begin
            cont[k] = (val >> (mvc_pkg::GROUP_BITS * (k + 1))) != 32'd0;
        end

        need = 3'(mvc_pkg::MAX_BYTES + 1);
        done = 1'b0;
        for (int k = 0; k < mvc_pkg::LANES; k++)
        begin
            if (!done && k < mvc_pkg::MAX_BYTES && !cont[k])
            begin
                need = 3'(k + 1);
                done = 1'b1;
            end
        end

        room_c = mvc_pkg::clamp_room(room);
        count  = (room_c < need) ? room_c : need;

        for (int k = 0; k < mvc_pkg::LANES; k++)
        begin
            if (3'(k) < count && k < mvc_pkg::MAX_BYTES)
            begin
                result.out_bytes[k] = {cont[k],
                                       val[mvc_pkg::GROUP_BITS * k +: mvc_pkg::GROUP_BITS]};
            end
            else
            begin
                result.out_bytes[k] = 8'd0;
            end
        end
        result.byte_count = count;
    end

endmodule

FILE: sv/mvc_decoder.sv
`timescale 1ns / 1ps

module mvc_decoder
(
    input  logic                                marked,
    input  logic [mvc_pkg::LANES-1:0][7:0]      in_bytes,
    input  logic [2:0]                          room,
    output mvc_pkg::dec_result_t                result
);

    logic [2:0]     lim;
    logic [2:0]     n;
    logic [27:0]    res;
    logic           stop;
    logic           last_nz;
    logic           canon;
    logic [2:0]     pos;
    logic           hit;
    logic [2:0]     level_new;
    logic [27:0]    shifted;
    logic           ok;

    function automatic logic [2:0] min_lim(input logic [2:0] r);
        logic [2:0] rc;
        rc = mvc_pkg::clamp_room(r);
        return (rc < 3'(mvc_pkg::MAX_BYTES)) ? rc : 3'(mvc_pkg::MAX_BYTES);
    endfunction

    always_comb
    begin
        lim = min_lim(room);
    end

    always_comb
    begin
        n       = 3'd0;
        res     = 28'd0;
        stop    = 1'b0;
        last_nz = 1'b0;
        // gather groups up to the first byte without continuation, within the room limit
        for (int k = 0; k < mvc_pkg::LANES; k++)
        begin
            if (!stop && 3'(k) < lim)
            begin
                n       = 3'(k + 1);
                res     = res | (28'(in_bytes[k][6:0]) << (mvc_pkg::GROUP_BITS * k));
                last_nz = in_bytes[k][6:0] != 7'd0;
                stop    = !in_bytes[k][7];
            end
        end
        // shortest form: a longer run must end in a nonzero group
        canon = (n == 3'd1) || last_nz;

        pos = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < mvc_pkg::MARK_SPAN; i++)
        begin
            if (!hit && res[i])
            begin
                pos = 3'(i);
                hit = 1'b1;
            end
        end
        level_new = pos + 3'd1;
        shifted   = res >> level_new;

        ok = stop && canon && (!marked || hit);

        result.out_value        = ok ? (marked ? shifted : res) : 28'd0;
        result.byte_count       = ok ? n : 3'd0;
        result.level_upd.update = ok && marked;
        result.level_upd.level  = level_new;
    end

endmodule

FILE: sv/mvc_level_regs.sv
`timescale 1ns / 1ps

module mvc_level_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  mvc_pkg::level_upd_t level_upd,
    output logic [2:0]          level
);

    logic [2:0] level_setting_reg;
    logic [2:0] level_setting_next;
    logic [2:0] current_level_reg;
    logic [2:0] current_level_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == mvc_pkg::LEVEL_REG_IDX);

    always_comb
    begin
        level_setting_next = level_setting_reg;
        current_level_next = current_level_reg;
        priority if (cfg_wr)
        begin
            level_setting_next = pwdata[2:0];
            current_level_next = pwdata[2:0];
        end
        else if (level_upd.update)
        begin
            current_level_next = level_upd.level;
        end
        else
        begin
            current_level_next = current_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_setting_reg <= 3'd0;
            current_level_reg <= 3'd0;
        end
        else
        begin
            level_setting_reg <= level_setting_next;
            current_level_reg <= current_level_next;
        end
    end

    assign prdata = (paddr[2] == mvc_pkg::LEVEL_REG_IDX) ? {29'd0, level_setting_reg} : 32'd0;
    assign level  = current_level_reg;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] LEVEL_ADDR = 3'(4 * mvc_pkg::LEVEL_REG_IDX);

    // Mirrors the codec: holds the current level and the results still owed by the block.
    class codec_tracker;
        bit [2:0]         level;
        bit [2:0]         level_set;
        mvc_pkg::result_t results_due[$];
        int               errors;
        int               compared;
        int               encodes;
        int               overflows;
        int               decodes;
        int               rejects;

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void write_level(input bit [2:0] lvl);
            level_set = lvl;
            level     = lvl;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void take_request(input logic act, input logic mk, input logic [31:0] v,
                                   input logic [3:0][7:0] ib, input logic [2:0] room);
            int               k;
            int               r;
            int               n;
            int               groups;
            int               found;
            int               cnt;
            bit               stop;
            logic [31:0]      w;
            logic [31:0]      acc;
            logic [31:0]      t;
            mvc_pkg::result_t e;

            e   = '0;
            cnt = 0;
            r   = (room > mvc_pkg::ROOM_LIMIT) ? int'(mvc_pkg::ROOM_LIMIT) : int'(room);
            if (act == mvc_pkg::ACT_ENCODE)
            begin
                encodes++;
                w = v;
                if (mk && level != 0)
                    w = (w << level) | (32'd1 << (level - 1));
                for (k = 0; k < r; k++)
                begin
                    cnt++;
                    if (cnt > mvc_pkg::MAX_BYTES)
                        break;
                    e.out_bytes[k] = {1'b0, w[6:0]};
                    w = w >> 7;
                    if (w != 0)
                        e.out_bytes[k][7] = 1'b1;
                    else
                        break;
                end
                if (cnt > mvc_pkg::MAX_BYTES)
                    overflows++;
            end
            else
            begin
                decodes++;
                acc  = '0;
                n    = 0;
                stop = 1'b0;
                for (k = 0; k < r && k < mvc_pkg::MAX_BYTES; k++)
                begin
                    n++;
                    acc = acc | ({25'b0, ib[k][6:0]} << (7 * k));
                    if (!ib[k][7])
                    begin
                        stop = 1'b1;
                        break;
                    end
                end
                // canonical length: the number of 7-bit groups the value really needs
                groups = 1;
                t      = acc >> 7;
                while (groups < mvc_pkg::MAX_BYTES && t != 0)
                begin
                    t = t >> 7;
                    groups++;
                end
                found = 0;
                if (mk)
                begin
                    for (k = 0; k < mvc_pkg::MARK_SPAN; k++)
                    begin
                        if (acc[k])
                        begin
                            found = k + 1;
                            break;
                        end
                    end
                end
                if (!stop || groups != n || (mk && found == 0))
                begin
                    rejects++;
                end
                else
                begin
                    if (mk)
                    begin
                        level = 3'(found);
                        acc   = acc >> found;
                    end
                    e.out_value = acc[27:0];
                    cnt         = n;
                end
            end
            e.byte_count = 3'(cnt);
            results_due.push_back(e);
        endfunction

        task check_result(input logic [63:0] raw);
            mvc_pkg::result_t got;
            mvc_pkg::result_t e;
            int               k;

            got = raw;
            if (results_due.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing outstanding", raw));
            end
            else
            begin
                e = results_due.pop_front();
                compared++;
                if (got.out_value !== e.out_value)
                    report($sformatf("result %0d out_value %h, want %h",
                                     compared, got.out_value, e.out_value));
                for (k = 0; k < mvc_pkg::LANES; k++)
                    if (got.out_bytes[k] !== e.out_bytes[k])
                        report($sformatf("result %0d out_byte%0d %h, want %h",
                                         compared, k, got.out_bytes[k], e.out_bytes[k]));
                if (got.byte_count !== e.byte_count)
                    report($sformatf("result %0d byte_count %0d, want %0d",
                                     compared, got.byte_count, e.byte_count));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // index_value, in_byte0..3, room, zero
    logic [1:0]  s_tuser  = '0;   // action, marked
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // out_value, out_byte0..3, byte_count, zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    codec_tracker book = new();
    bit           calm = 1'b0;
    int           stall_left = 0;

    marked_varint_codec_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver back-pressure in short bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 4);
        m_tready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_result(m_tdata);
    end

    task automatic send_req(input logic act, input logic mk, input logic [31:0] v,
                            input logic [3:0][7:0] ib, input logic [2:0] room);
        s_tdata  <= {5'b0, room, ib, v};
        s_tuser  <= {mk, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        book.take_request(act, mk, v, ib, room);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Hold off until every request has been answered
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_level(input logic [2:0] lvl);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEVEL_ADDR;
        pwdata  <= {29'b0, lvl};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        book.write_level(lvl);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {29'b0, lvl})
            book.report($sformatf("level_setting reads %h, want %h", prdata, lvl));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_req();
        int              pick;
        int              len;
        int              p;
        logic            mk;
        logic [31:0]     v;
        logic [3:0][7:0] ib;
        logic [2:0]      room;

        pick = $urandom_range(0, 99);
        mk   = 1'($urandom_range(0, 1));
        ib   = $urandom;
        if (pick < 40)
        begin
            v    = $urandom >> $urandom_range(0, 31);
            room = 3'($urandom_range(0, 7));
            send_req(mvc_pkg::ACT_ENCODE, mk, v, ib, room);
        end
        else if (pick < 85)
        begin
            // well-formed varint of a chosen length, sometimes with too little room
            len = $urandom_range(1, mvc_pkg::MAX_BYTES);
            v   = $urandom & ((32'd1 << (mvc_pkg::GROUP_BITS * len)) - 1);
            if (len > 1)
                v[mvc_pkg::GROUP_BITS * (len - 1) +: mvc_pkg::GROUP_BITS] =
                    7'($urandom_range(1, 127));
            if (mk && $urandom_range(0, 3) != 0)
            begin
                p = $urandom_range(0, mvc_pkg::MARK_SPAN);
                v = (v & ~((32'd2 << p) - 1)) | (32'd1 << p);
            end
            for (int k = 0; k < len; k++)
                ib[k] = {(k < len - 1), v[mvc_pkg::GROUP_BITS * k +: mvc_pkg::GROUP_BITS]};
            if ($urandom_range(0, 4) == 0)
                room = 3'($urandom_range(0, 7));
            else
                room = 3'($urandom_range(len, 7));
            send_req(mvc_pkg::ACT_DECODE, mk, $urandom, ib, room);
        end
        else
        begin
            send_req(mvc_pkg::ACT_DECODE, mk, $urandom, ib, 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        logic [2:0] phase_levels [8];

        phase_levels = '{3'd1, 3'd6, 3'd3, 3'd5, 3'd2, 3'd4, 3'd7, 3'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_level(3'd0);

        // encode: smallest and largest values, overflow, room zero and short room
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'd0,          32'hA5A5_5A5A, 3'd1);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'd127,        32'hA5A5_5A5A, 3'd1);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'd128,        32'hA5A5_5A5A, 3'd2);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'hFFFF_FFFF,  32'hA5A5_5A5A, 3'd5);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'h0FFF_FFFF,  32'hA5A5_5A5A, 3'd4);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'h1000_0000,  32'hA5A5_5A5A, 3'd7);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'd300,        32'hA5A5_5A5A, 3'd0);
        send_req(mvc_pkg::ACT_ENCODE, 1'b0, 32'd16384,      32'hA5A5_5A5A, 3'd2);
        // decode: extremes, missing terminator, short room, non-canonical, room zero
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_0000, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_007F, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_0180, 3'd2);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h7FFF_FFFF, 3'd4);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h8080_8080, 3'd5);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_0180, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_0080, 3'd2);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'h0000_0000, 3'd0);
        send_req(mvc_pkg::ACT_DECODE, 1'b0, 32'h1234_5678,  32'hFFFF_FFFF, 3'd7);
        // marked decode: lowest set bit at 0, beyond the span, none, at the top of the span
        send_req(mvc_pkg::ACT_DECODE, 1'b1, 32'h1234_5678,  32'h0000_0001, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b1, 32'h1234_5678,  32'h0000_0040, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b1, 32'h1234_5678,  32'h0000_0000, 3'd1);
        send_req(mvc_pkg::ACT_DECODE, 1'b1, 32'h1234_5678,  32'h0000_0020, 3'd1);
        send_req(mvc_pkg::ACT_ENCODE, 1'b1, 32'hFFFF_FFFF,  32'hA5A5_5A5A, 3'd5);
        drain();
        set_level(3'd7);
        send_req(mvc_pkg::ACT_ENCODE, 1'b1, 32'hFFFF_FFFF,  32'hA5A5_5A5A, 3'd5);
        send_req(mvc_pkg::ACT_ENCODE, 1'b1, 32'd1,          32'hA5A5_5A5A, 3'd3);
        drain();
        set_level(3'd0);
        send_req(mvc_pkg::ACT_ENCODE, 1'b1, 32'd5,          32'hA5A5_5A5A, 3'd2);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            set_level(phase_levels[ph]);
            if (ph == 7)
                calm = 1'b1;
            repeat (230) random_req();
        end

        drain();
        $display("covered %0d encodes (%0d overflowing) and %0d decodes (%0d rejected)",
                 book.encodes, book.overflows, book.decodes, book.rejects);
        $display("compared %0d results across all eight level settings", book.compared);
        if (book.errors == 0 && book.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", book.pending());
        $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mvc_pkg.sv
sv/mvc_encoder.sv
sv/mvc_decoder.sv
sv/mvc_level_regs.sv
sv/marked_varint_codec_unit.sv
bench/tb.sv
